### hdl/tlqbs_pkg.sv
// types, codes and defaults shared by the three-level queue scheduler
package tlqbs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int NUM_LEVELS = 3;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_SERVE  = 1'b1;

   localparam logic [2:0] STAT_APPENDED = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_FINISHED = 3'd2;
   localparam logic [2:0] STAT_REQUEUED = 3'd3;
   localparam logic [2:0] STAT_EMPTY    = 3'd4;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  level;
      logic [7:0]  job_id;
      logic [15:0] burst_time;
      logic [15:0] budget;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_job_id;
      logic [15:0] remaining;
      logic [15:0] leftover;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] burst;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_APPEND,
      S_READ,
      S_EVAL
   } state_type;

endpackage

### hdl/tlqbs_qmem.sv
// one job queue memory, one write port and one registered read port
module tlqbs_qmem #(
   parameter int DEPTH = tlqbs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WIDTH = tlqbs_pkg::JOB_W,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tlqbs_ctrl.sv
// sequencer: queue pointers, budget walk and result register
module tlqbs_ctrl #(
   parameter int QUEUE_DEPTH = tlqbs_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1),
   localparam int NL = tlqbs_pkg::NUM_LEVELS,
   localparam int JW = tlqbs_pkg::JOB_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tlqbs_pkg::req_type        req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tlqbs_pkg::rsp_type        rsp_data,
   output logic [NL-1:0]             mem_wr_en,
   output logic [NL-1:0][AW-1:0]     mem_wr_addr,
   output logic [NL-1:0][JW-1:0]     mem_wr_data,
   output logic [NL-1:0]             mem_rd_en,
   output logic [NL-1:0][AW-1:0]     mem_rd_addr,
   input  logic [NL-1:0][JW-1:0]     mem_rd_data
);

   tlqbs_pkg::state_type  state_ff, state_in;
   logic [NL-1:0][AW-1:0] head_ff, head_in;
   logic [NL-1:0][CW-1:0] count_ff, count_in;
   logic [NL-1:0][AW-1:0] tail;
   tlqbs_pkg::req_type    req_ff, req_in;
   logic [15:0]           left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tlqbs_pkg::rsp_type    rsp_ff, rsp_in;

   tlqbs_pkg::job_type    head_job;
   tlqbs_pkg::job_type    new_job;
   logic                  out_free;
   logic                  fits;
   logic [15:0]           left_after;
   logic [15:0]           rem_after;
   logic                  l2_moves;
   logic                  l3_moves;
   logic                  append_ok;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
      logic [AW:0] s;
      s = {1'b0, h} + (AW+1)'(c);
      if (s >= (AW+1)'(QUEUE_DEPTH)) begin
         s = s - (AW+1)'(QUEUE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] next_head(input logic [AW-1:0] h);
      return (h == AW'(QUEUE_DEPTH - 1)) ? '0 : h + AW'(1);
   endfunction

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         tail[i] = wrap_add(head_ff[i], count_ff[i]);
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign head_job   = tlqbs_pkg::job_type'(mem_rd_data[0]);
   assign fits       = left_ff >= head_job.burst;
   assign left_after = left_ff - head_job.burst;
   assign rem_after  = head_job.burst - left_ff;
   assign l2_moves   = count_ff[1] != '0;
   assign l3_moves   = count_ff[2] != '0;
   assign new_job    = '{id: req_ff.job_id, burst: req_ff.burst_time};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      left_in      = left_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr_en    = '0;
      mem_wr_addr  = tail;
      mem_wr_data  = '0;
      mem_rd_en    = '0;
      mem_rd_addr  = head_ff;
      append_ok    = 1'b0;
      req_stall    = state_ff != tlqbs_pkg::S_IDLE;

      case (state_ff)
         tlqbs_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               left_in = req_data.budget;
               state_in = (req_data.cmd == tlqbs_pkg::CMD_APPEND) ?
                          tlqbs_pkg::S_APPEND : tlqbs_pkg::S_READ;
            end
         end
         tlqbs_pkg::S_APPEND: begin
            if (out_free) begin
               for (int i = 0; i < NL; i++) begin
                  if (req_ff.level == 2'(i) && count_ff[i] != CW'(QUEUE_DEPTH)) begin
                     append_ok      = 1'b1;
                     mem_wr_en[i]   = 1'b1;
                     mem_wr_data[i] = new_job;
                     count_in[i]    = count_ff[i] + CW'(1);
                  end
               end
               rsp_in.status     = append_ok ? tlqbs_pkg::STAT_APPENDED : tlqbs_pkg::STAT_FULL;
               rsp_in.out_job_id = req_ff.job_id;
               rsp_in.remaining  = req_ff.burst_time;
               rsp_in.leftover   = '0;
               rsp_in.last       = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = tlqbs_pkg::S_IDLE;
            end
         end
         tlqbs_pkg::S_READ: begin
            if (count_ff[0] == '0) begin
               if (out_free) begin
                  rsp_in.status     = tlqbs_pkg::STAT_EMPTY;
                  rsp_in.out_job_id = '0;
                  rsp_in.remaining  = '0;
                  rsp_in.leftover   = left_ff;
                  rsp_in.last       = 1'b1;
                  rsp_valid_in      = 1'b1;
                  state_in          = tlqbs_pkg::S_IDLE;
               end
            end else begin
               mem_rd_en = '1;
               state_in  = tlqbs_pkg::S_EVAL;
            end
         end
         tlqbs_pkg::S_EVAL: begin
            if (out_free) begin
               rsp_in.out_job_id = head_job.id;
               rsp_valid_in      = 1'b1;
               head_in[0]        = next_head(head_ff[0]);
               if (fits) begin
                  // head done, level two head drops to level one, level three to level two
                  rsp_in.status    = tlqbs_pkg::STAT_FINISHED;
                  rsp_in.remaining = '0;
                  rsp_in.leftover  = left_after;
                  rsp_in.last      = 1'b0;
                  left_in          = left_after;
                  mem_wr_en[0]     = l2_moves;
                  mem_wr_data[0]   = mem_rd_data[1];
                  mem_wr_en[1]     = l3_moves;
                  mem_wr_data[1]   = mem_rd_data[2];
                  if (l2_moves) begin
                     head_in[1] = next_head(head_ff[1]);
                  end
                  if (l3_moves) begin
                     head_in[2] = next_head(head_ff[2]);
                  end
                  count_in[0] = count_ff[0] - CW'(1) + CW'(l2_moves);
                  count_in[1] = count_ff[1] - CW'(l2_moves) + CW'(l3_moves);
                  count_in[2] = count_ff[2] - CW'(l3_moves);
                  state_in    = tlqbs_pkg::S_READ;
               end else begin
                  rsp_in.status    = tlqbs_pkg::STAT_REQUEUED;
                  rsp_in.remaining = rem_after;
                  rsp_in.leftover  = '0;
                  rsp_in.last      = 1'b1;
                  left_in          = '0;
                  mem_wr_en[0]     = 1'b1;
                  mem_wr_data[0]   = tlqbs_pkg::job_type'{id: head_job.id, burst: rem_after};
                  state_in         = tlqbs_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = tlqbs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlqbs_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/three_level_queue_budget_scheduler.sv
// top level: three-level job queue scheduler with time budget serving
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   req_data  (tlqbs_pkg::req_type)
//  rsp_      out        rsp_valid/rsp_stall   rsp_data  (tlqbs_pkg::rsp_type)
//
// an append: the append state registers the result and returns to idle, where the next request
// can be taken in the same cycle that the result becomes valid; a serve: a read state reads the
// queue heads and an evaluate state registers each result, a finished job going back to the read
// state; finished and requeued results each wait for a read of the queue memories
// reset clears pointers, counts and the result valid; queue contents stay undefined
// a stalled result holds the sequencer in the states that write a result, and a new request is taken while it waits
module three_level_queue_budget_scheduler #(
   parameter int QUEUE_DEPTH = tlqbs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlqbs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlqbs_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int NL = tlqbs_pkg::NUM_LEVELS;
   localparam int JW = tlqbs_pkg::JOB_W;

   logic [NL-1:0]         mem_wr_en;
   logic [NL-1:0][AW-1:0] mem_wr_addr;
   logic [NL-1:0][JW-1:0] mem_wr_data;
   logic [NL-1:0]         mem_rd_en;
   logic [NL-1:0][AW-1:0] mem_rd_addr;
   logic [NL-1:0][JW-1:0] mem_rd_data;

   tlqbs_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   for (genvar g = 0; g < NL; g++) begin : g_level
      tlqbs_qmem #(
         .DEPTH(QUEUE_DEPTH),
         .WIDTH(JW)
      ) u_qmem (
         .clock   (clock),
         .wr_en   (mem_wr_en[g]),
         .wr_addr (mem_wr_addr[g]),
         .wr_data (mem_wr_data[g]),
         .rd_en   (mem_rd_en[g]),
         .rd_addr (mem_rd_addr[g]),
         .rd_data (mem_rd_data[g])
      );
   end

endmodule

### hdl/tlqbs_checker.sv
// port-level checks for the three-level queue scheduler, bound to the top level
module tlqbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input tlqbs_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input tlqbs_pkg::rsp_type rsp_data
);

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one request in flight at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // append results echo the request and end it
   a_append_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == tlqbs_pkg::STAT_APPENDED ||
                    rsp_data.status == tlqbs_pkg::STAT_FULL)
      |-> rsp_data.last && rsp_data.leftover == '0)
      else $error("bad append result");

   // requeue ends the serve with the budget spent
   a_requeue_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == tlqbs_pkg::STAT_REQUEUED
      |-> rsp_data.last && rsp_data.leftover == '0)
      else $error("bad requeue result");

   // finished jobs and the empty marker carry no remaining time
   a_serve_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == tlqbs_pkg::STAT_FINISHED ||
                    rsp_data.status == tlqbs_pkg::STAT_EMPTY)
      |-> rsp_data.remaining == '0 &&
          (rsp_data.last == (rsp_data.status == tlqbs_pkg::STAT_EMPTY)))
      else $error("bad serve result");

endmodule

bind three_level_queue_budget_scheduler tlqbs_checker u_checker (.*);
